/* rtl/core/lzbtd_pkg.sv */
// Package for the LZ bit stream token decoder: word types, codes and constants.
`default_nettype none

package lzbtd_pkg;

  localparam int POSITION_BITS_DEF = 24;
  localparam int CAP_W             = 24;
  localparam int STORE_W           = 56;
  localparam int HELD_W            = 6;
  localparam int POS_OUT_W         = 24;
  localparam int OFF_W             = 21;
  localparam int LEN_W             = 13;
  localparam int WIN_W             = 23;

  localparam logic [CAP_W-1:0] CAP_RESET = 24'hFF_FFFF;

  // offset bases for the 6, 9, 12 and 20 bit forms
  localparam logic [OFF_W-1:0] BASE_6  = 21'h00_0001;
  localparam logic [OFF_W-1:0] BASE_9  = 21'h00_0041;
  localparam logic [OFF_W-1:0] BASE_12 = 21'h00_0241;
  localparam logic [OFF_W-1:0] BASE_20 = 21'h00_1241;
  localparam logic [19:0]      END_MARK = 20'hF_FFFF;

  localparam logic [HELD_W-1:0] LIT_BITS     = 6'd9;
  localparam logic [HELD_W-1:0] BYTE_BITS    = 6'd8;
  localparam logic [3:0]        PREFIX_OVER  = 4'd12;

  typedef enum logic [1:0] {
    TK_LITERAL = 2'd0,
    TK_COPY    = 2'd1,
    TK_END     = 2'd2,
    TK_ERROR   = 2'd3
  } token_kind_t;

  typedef enum logic [1:0] {
    ERR_FLAG     = 2'd0,
    ERR_PREFIX   = 2'd1,
    ERR_OFFSET   = 2'd2,
    ERR_CAPACITY = 2'd3
  } error_code_t;

  typedef enum logic [1:0] {
    PH_AWAIT   = 2'd0,
    PH_DECODE  = 2'd1,
    PH_STOPPED = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } lzbtd_in_t;

  typedef struct packed {
    logic [1:0]           token_kind;
    logic [7:0]           literal_value;
    logic [OFF_W-1:0]     copy_offset;
    logic [LEN_W-1:0]     copy_length;
    logic [POS_OUT_W-1:0] out_position;
    logic [1:0]           error_code;
  } lzbtd_out_t;

  // outcome of decoding one word in the decode phase
  typedef struct packed {
    logic              emit;
    logic              stop;
    logic              bump;
    token_kind_t       kind;
    error_code_t       code;
    logic [HELD_W-1:0] used;
  } lzbtd_dec_t;

endpackage

`default_nettype wire

/* rtl/core/lz_bitstream_token_decoder.sv */
// Top level of the LZ bit stream token decoder: bit store, token decode, result register.
`default_nettype none

//  channel | ports                        | direction | payload
//  --------+------------------------------+-----------+----------------------------
//  in      | in_valid, in_ready, in_data  | input     | compressed byte, stream start
//  out     | out_valid, out_ready, out_data| output   | token or error
//  cfg     | cfg_wr_en, cfg_wr_data       | input     | destination capacity
//
// One word is taken per cycle while in_ready is high; each one is decoded in the cycle it is taken and its
// token, if any, lands in the result register on the same edge.
// in_ready is high whenever the result register is empty or being drained.
// Synchronous active-low reset: phase to awaiting flag byte, store empty, capacity max.

module lz_bitstream_token_decoder #(
  parameter int POSITION_BITS = lzbtd_pkg::POSITION_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire lzbtd_pkg::lzbtd_in_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output lzbtd_pkg::lzbtd_out_t      out_data,
  input  wire logic                  cfg_wr_en,
  input  wire logic [lzbtd_pkg::CAP_W-1:0] cfg_wr_data
);

  localparam int SW = lzbtd_pkg::STORE_W;
  localparam int HW = lzbtd_pkg::HELD_W;
  localparam int LW = lzbtd_pkg::LEN_W;
  localparam int CW = (POSITION_BITS > lzbtd_pkg::CAP_W) ? POSITION_BITS : lzbtd_pkg::CAP_W;

  lzbtd_pkg::phase_t            phase_r, phase_nxt;
  logic [SW-1:0]                store_r, store_nxt;
  logic [HW-1:0]                held_r, held_nxt;
  logic [POSITION_BITS-1:0]     bp_r, bp_nxt;
  logic [lzbtd_pkg::CAP_W-1:0]  cap_r;
  logic                         out_valid_r, out_valid_nxt;
  lzbtd_pkg::lzbtd_out_t        out_data_r, out_data_nxt;

  logic                         accept;
  logic                         flag_word;
  logic [SW-1:0]                s;
  logic [HW-1:0]                h;
  logic [4:0]                   pos;
  logic                         is_lit;
  logic                         hdr_ok;
  logic                         end_mark;
  logic [1:0]                   cb;
  logic [lzbtd_pkg::OFF_W-1:0]  dib;
  logic [lzbtd_pkg::WIN_W-1:0]  win;
  logic [3:0]                   z;
  logic [HW-1:0]                avail;
  logic                         pre_ok;
  logic [HW-1:0]                need;
  logic [10:0]                  vmask;
  logic [10:0]                  v;
  logic [LW-1:0]                len;
  logic [CW-1:0]                bpx;
  logic [CW-1:0]                capx;
  logic [CW-1:0]                room;
  lzbtd_pkg::lzbtd_dec_t        dec;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign flag_word = in_data.stream_start || (phase_r == lzbtd_pkg::PH_AWAIT);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // incoming byte joins the store above the bits already held (held never exceeds 46)
  assign s = store_r | ({{(SW-8){1'b0}}, in_data.in_byte} << held_r);
  assign h = held_r + lzbtd_pkg::BYTE_BITS;

  assign bpx  = CW'(bp_r);
  assign capx = CW'(cap_r);
  assign room = (bpx >= capx) ? '0 : capx - bpx;

  // token header: kind, offset form, and a window starting at the length prefix
  always_comb begin
    is_lit   = 1'b0;
    hdr_ok   = 1'b0;
    end_mark = 1'b0;
    cb       = 2'd1;
    pos      = 5'd8;
    dib      = '0;
    win      = '0;
    if (!s[0]) begin
      is_lit = 1'b1;
    end else if (!s[1]) begin
      hdr_ok = 1'b1;
      pos    = 5'd8;
      dib    = {15'b0, s[7:2]} + lzbtd_pkg::BASE_6;
      win    = s[30:8];
    end else if (!s[2]) begin
      hdr_ok = (h >= 6'd12);
      pos    = 5'd12;
      dib    = {12'b0, s[11:3]} + lzbtd_pkg::BASE_9;
      win    = s[34:12];
    end else if (!s[3]) begin
      hdr_ok = (h >= 6'd16);
      pos    = 5'd16;
      dib    = {9'b0, s[15:4]} + lzbtd_pkg::BASE_12;
      win    = s[38:16];
    end else begin
      hdr_ok   = (h >= 6'd24);
      end_mark = (s[23:4] == lzbtd_pkg::END_MARK);
      cb       = 2'd2;
      pos      = 5'd24;
      dib      = {1'b0, s[23:4]} + lzbtd_pkg::BASE_20;
      win      = s[46:24];
    end
  end

  // unary length prefix: first zero in the window, or twelve if none
  always_comb begin
    z = lzbtd_pkg::PREFIX_OVER;
    for (int i = 11; i >= 0; i--) begin
      if (!win[i]) begin
        z = 4'(i);
      end
    end
  end

  assign avail  = h - {1'b0, pos};
  assign pre_ok = (z == lzbtd_pkg::PREFIX_OVER) ? (avail >= HW'(lzbtd_pkg::PREFIX_OVER))
                                                : (avail > {2'b0, z});
  assign need   = {1'b0, pos} + {1'b0, z, 1'b0} + 6'd1;
  assign vmask  = ~(11'h7FF << z);
  assign v      = 11'(win >> (z + 4'd1)) & vmask;
  assign len    = {11'b0, cb} + (13'd1 << z) + {2'b0, v};

  // outcome of one word in the decode phase
  always_comb begin
    dec      = '0;
    dec.kind = lzbtd_pkg::TK_LITERAL;
    dec.code = lzbtd_pkg::ERR_FLAG;
    if (is_lit) begin
      if (h >= lzbtd_pkg::LIT_BITS) begin
        dec.emit = 1'b1;
        if (bpx >= capx) begin
          dec.stop = 1'b1;
          dec.kind = lzbtd_pkg::TK_ERROR;
          dec.code = lzbtd_pkg::ERR_CAPACITY;
        end else begin
          dec.bump = 1'b1;
          dec.used = lzbtd_pkg::LIT_BITS;
        end
      end
    end else if (hdr_ok) begin
      if (end_mark) begin
        dec.emit = 1'b1;
        dec.stop = 1'b1;
        dec.kind = lzbtd_pkg::TK_END;
      end else if (pre_ok) begin
        if (z == lzbtd_pkg::PREFIX_OVER) begin
          dec.emit = 1'b1;
          dec.stop = 1'b1;
          dec.kind = lzbtd_pkg::TK_ERROR;
          dec.code = lzbtd_pkg::ERR_PREFIX;
        end else if (need <= h) begin
          dec.emit = 1'b1;
          if (room < CW'(len)) begin
            dec.stop = 1'b1;
            dec.kind = lzbtd_pkg::TK_ERROR;
            dec.code = lzbtd_pkg::ERR_CAPACITY;
          end else if (bpx < CW'(dib)) begin
            dec.stop = 1'b1;
            dec.kind = lzbtd_pkg::TK_ERROR;
            dec.code = lzbtd_pkg::ERR_OFFSET;
          end else begin
            dec.kind = lzbtd_pkg::TK_COPY;
            dec.bump = 1'b1;
            dec.used = need;
          end
        end
      end
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      if (flag_word) begin
        phase_nxt = (in_data.in_byte != 8'd0) ? lzbtd_pkg::PH_STOPPED : lzbtd_pkg::PH_DECODE;
      end else begin
        case (phase_r)
          lzbtd_pkg::PH_DECODE: begin
            if (dec.stop) begin
              phase_nxt = lzbtd_pkg::PH_STOPPED;
            end
          end
          default: phase_nxt = phase_r;
        endcase
      end
    end
  end

  // store, position and result word
  always_comb begin
    store_nxt     = store_r;
    held_nxt      = held_r;
    bp_nxt        = bp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (accept) begin
      if (flag_word) begin
        store_nxt = '0;
        held_nxt  = '0;
        bp_nxt    = '0;
        if (in_data.in_byte != 8'd0) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.token_kind = lzbtd_pkg::TK_ERROR;
          out_data_nxt.error_code = lzbtd_pkg::ERR_FLAG;
        end
      end else if (phase_r == lzbtd_pkg::PH_DECODE) begin
        store_nxt = s;
        held_nxt  = h;
        if (dec.emit) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.token_kind    = dec.kind;
          out_data_nxt.literal_value = (dec.kind == lzbtd_pkg::TK_LITERAL) ? s[8:1] : 8'd0;
          out_data_nxt.copy_offset   = (dec.kind == lzbtd_pkg::TK_COPY) ? dib : '0;
          out_data_nxt.copy_length   = (dec.kind == lzbtd_pkg::TK_COPY) ? len : '0;
          out_data_nxt.out_position  = bpx[lzbtd_pkg::POS_OUT_W-1:0];
          out_data_nxt.error_code    = (dec.kind == lzbtd_pkg::TK_ERROR) ? dec.code
                                                                         : lzbtd_pkg::ERR_FLAG;
        end
        if (dec.stop) begin
          store_nxt = '0;
          held_nxt  = '0;
        end else if (dec.bump) begin
          store_nxt = s >> dec.used;
          held_nxt  = h - dec.used;
          bp_nxt    = (dec.kind == lzbtd_pkg::TK_LITERAL)
                    ? bp_r + POSITION_BITS'(1)
                    : bp_r + {{(POSITION_BITS-LW){1'b0}}, len};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lzbtd_pkg::PH_AWAIT;
      store_r     <= '0;
      held_r      <= '0;
      bp_r        <= '0;
      cap_r       <= lzbtd_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      store_r     <= store_nxt;
      held_r      <= held_nxt;
      bp_r        <= bp_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

/* tb/lzbtd_token_checker.sv */
// Token checker: predicts the decoder's tokens from accepted words and compares results.
`timescale 1ns / 1ps

module lzbtd_token_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire lzbtd_pkg::lzbtd_in_t        in_data,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire lzbtd_pkg::lzbtd_out_t       out_data,
  input  wire logic                        cfg_wr_en,
  input  wire logic [lzbtd_pkg::CAP_W-1:0] cfg_wr_data,
  output int                               mismatches,
  output int                               tokens_owed
);

  // code field reads zero for anything that is not an error
  localparam lzbtd_pkg::error_code_t NO_ERROR = lzbtd_pkg::ERR_FLAG;

  logic [63:0]                     store;
  int unsigned                     held;
  lzbtd_pkg::phase_t               phase;
  logic [lzbtd_pkg::POS_OUT_W-1:0] produced;
  logic [lzbtd_pkg::CAP_W-1:0]     capacity;
  lzbtd_pkg::lzbtd_out_t           expected_tokens[$];

  function automatic logic [31:0] bits_at(int unsigned p, int unsigned n);
    if (p >= 64 || n == 0) return '0;
    return 32'((store >> p) & ((64'd1 << n) - 64'd1));
  endfunction

  function automatic void drop_bits(int unsigned n);
    store = store >> n;
    held  = (n >= held) ? 0 : held - n;
  endfunction

  function automatic lzbtd_pkg::lzbtd_out_t make_token(lzbtd_pkg::token_kind_t kind,
                                                       logic [7:0] lit,
                                                       logic [31:0] offs, logic [31:0] len,
                                                       lzbtd_pkg::error_code_t code);
    lzbtd_pkg::lzbtd_out_t t;
    t.token_kind    = kind;
    t.literal_value = lit;
    t.copy_offset   = offs[lzbtd_pkg::OFF_W-1:0];
    t.copy_length   = len[lzbtd_pkg::LEN_W-1:0];
    t.out_position  = produced;
    t.error_code    = code;
    return t;
  endfunction

  // end of data or error: the stream stops until the next start word
  function automatic lzbtd_pkg::lzbtd_out_t halt(lzbtd_pkg::token_kind_t kind,
                                                 lzbtd_pkg::error_code_t code);
    lzbtd_pkg::lzbtd_out_t t;
    t     = make_token(kind, '0, '0, '0, code);
    store = '0;
    held  = 0;
    phase = lzbtd_pkg::PH_STOPPED;
    return t;
  endfunction

  function automatic bit next_token(output lzbtd_pkg::lzbtd_out_t t);
    int unsigned pos, ones, base_len;
    logic [31:0] offs, len, room;
    ones     = 0;
    base_len = 1;
    t        = '0;
    if (held < 1) return 0;
    if (bits_at(0, 1) == 0) begin
      if (held < lzbtd_pkg::LIT_BITS) return 0;
      if (produced >= capacity) begin
        t = halt(lzbtd_pkg::TK_ERROR, lzbtd_pkg::ERR_CAPACITY);
        return 1;
      end
      t        = make_token(lzbtd_pkg::TK_LITERAL, 8'(bits_at(1, 8)), '0, '0, NO_ERROR);
      produced = produced + 1'b1;
      drop_bits(lzbtd_pkg::LIT_BITS);
      return 1;
    end
    if (held < 2) return 0;
    if (bits_at(1, 1) == 0) begin
      if (held < 8) return 0;
      offs = bits_at(2, 6) + lzbtd_pkg::BASE_6;
      pos  = 8;
    end else begin
      if (held < 3) return 0;
      if (bits_at(2, 1) == 0) begin
        if (held < 12) return 0;
        offs = bits_at(3, 9) + lzbtd_pkg::BASE_9;
        pos  = 12;
      end else begin
        if (held < 4) return 0;
        if (bits_at(3, 1) == 0) begin
          if (held < 16) return 0;
          offs = bits_at(4, 12) + lzbtd_pkg::BASE_12;
          pos  = 16;
        end else begin
          if (held < 24) return 0;
          offs = bits_at(4, 20);
          if (offs == lzbtd_pkg::END_MARK) begin
            t = halt(lzbtd_pkg::TK_END, NO_ERROR);
            return 1;
          end
          offs     = offs + lzbtd_pkg::BASE_20;
          base_len = 2;
          pos      = 24;
        end
      end
    end
    // unary length prefix, terminated by a zero bit
    forever begin
      if (pos + ones >= held) return 0;
      if (bits_at(pos + ones, 1) == 0) break;
      ones++;
      if (ones >= lzbtd_pkg::PREFIX_OVER) begin
        t = halt(lzbtd_pkg::TK_ERROR, lzbtd_pkg::ERR_PREFIX);
        return 1;
      end
    end
    if (pos + 2 * ones + 1 > held) return 0;
    len  = base_len + (32'd1 << ones) + bits_at(pos + ones + 1, ones);
    room = (produced >= capacity) ? '0 : 32'(capacity - produced);
    // capacity is checked ahead of the offset
    if (room < len) begin
      t = halt(lzbtd_pkg::TK_ERROR, lzbtd_pkg::ERR_CAPACITY);
      return 1;
    end
    if (32'(produced) < offs) begin
      t = halt(lzbtd_pkg::TK_ERROR, lzbtd_pkg::ERR_OFFSET);
      return 1;
    end
    t        = make_token(lzbtd_pkg::TK_COPY, '0, offs, len, NO_ERROR);
    produced = produced + len[lzbtd_pkg::POS_OUT_W-1:0];
    drop_bits(pos + 2 * ones + 1);
    return 1;
  endfunction

  function automatic bit decode_word(lzbtd_pkg::lzbtd_in_t w,
                                     output lzbtd_pkg::lzbtd_out_t t);
    t = '0;
    if (w.stream_start || phase == lzbtd_pkg::PH_AWAIT) begin
      store    = '0;
      held     = 0;
      produced = '0;
      if (w.in_byte != 0) begin
        t = halt(lzbtd_pkg::TK_ERROR, lzbtd_pkg::ERR_FLAG);
        return 1;
      end
      phase = lzbtd_pkg::PH_DECODE;
      return 0;
    end
    if (phase != lzbtd_pkg::PH_DECODE) return 0;
    store = store | (64'(w.in_byte) << held);
    held  = held + lzbtd_pkg::BYTE_BITS;
    return next_token(t);
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    lzbtd_pkg::lzbtd_out_t want;
    if (!rst_n) begin
      store      = '0;
      held       = 0;
      phase      = lzbtd_pkg::PH_AWAIT;
      produced   = '0;
      capacity   = lzbtd_pkg::CAP_RESET;
      mismatches = 0;
      expected_tokens.delete();
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          report("token with none due", 32'(out_data.token_kind), '0);
        end else begin
          want = expected_tokens.pop_front();
          if (out_data.token_kind !== want.token_kind)
            report("token_kind", 32'(out_data.token_kind), 32'(want.token_kind));
          if (out_data.literal_value !== want.literal_value)
            report("literal_value", 32'(out_data.literal_value), 32'(want.literal_value));
          if (out_data.copy_offset !== want.copy_offset)
            report("copy_offset", 32'(out_data.copy_offset), 32'(want.copy_offset));
          if (out_data.copy_length !== want.copy_length)
            report("copy_length", 32'(out_data.copy_length), 32'(want.copy_length));
          if (out_data.out_position !== want.out_position)
            report("out_position", 32'(out_data.out_position), 32'(want.out_position));
          if (out_data.error_code !== want.error_code)
            report("error_code", 32'(out_data.error_code), 32'(want.error_code));
        end
      end
      if (in_valid && in_ready) begin
        if (decode_word(in_data, want)) expected_tokens.push_back(want);
      end
    end
    tokens_owed <= expected_tokens.size();
  end

endmodule

/* tb/testbench.sv */
// Testbench top: encodes compressed streams, drives the decoder and gives the verdict.
`timescale 1ns / 1ps

module testbench;

  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT        = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int unsigned MAX_ONES = lzbtd_pkg::PREFIX_OVER - 1;
  localparam int unsigned FAR_DIST = lzbtd_pkg::BASE_20 + lzbtd_pkg::END_MARK - 1;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  lzbtd_pkg::lzbtd_in_t        in_data;
  logic                        out_valid;
  logic                        out_ready;
  lzbtd_pkg::lzbtd_out_t       out_data;
  logic                        cfg_wr_en;
  logic [lzbtd_pkg::CAP_W-1:0] cfg_wr_data;
  int                          mismatches;
  int                          tokens_owed;

  logic        quiet;
  logic        hold_req;
  logic        hold_done;
  int          sent;
  int          idle_run;
  bit          bitq[$];
  int unsigned enc_produced;

  always #1 clk = ~clk;

  lz_bitstream_token_decoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  lzbtd_token_checker token_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatches),
    .tokens_owed (tokens_owed)
  );

  // nothing moving on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run == LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(logic [7:0] b, logic s);
    lzbtd_pkg::lzbtd_in_t w;
    w.in_byte      = b;
    w.stream_start = s;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(logic [lzbtd_pkg::CAP_W-1:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // bits go out least significant first
  task automatic put_bits(logic [31:0] val, int unsigned n);
    for (int i = 0; i < n; i++) bitq.push_back(val[i]);
  endtask

  task automatic flush_bytes();
    logic [7:0] b;
    while (bitq.size() >= 8) begin
      for (int i = 0; i < 8; i++) b[i] = bitq.pop_front();
      send_word(b, 1'b0);
    end
  endtask

  task automatic finish_bits();
    while (bitq.size() % 8 != 0) bitq.push_back(1'($urandom_range(0, 1)));
    flush_bytes();
  endtask

  task automatic open_stream(logic s, logic [7:0] flag);
    bitq.delete();
    enc_produced = 0;
    send_word(flag, s);
  endtask

  task automatic put_literal(logic [7:0] b);
    put_bits(32'h0, 1);
    put_bits(32'(b), 8);
    enc_produced++;
    flush_bytes();
  endtask

  task automatic put_copy(int unsigned offs, int unsigned ones, int unsigned v);
    int unsigned base_len;
    base_len = 1;
    if (offs < lzbtd_pkg::BASE_9) begin
      put_bits(32'b01, 2);
      put_bits(offs - lzbtd_pkg::BASE_6, 6);
    end else if (offs < lzbtd_pkg::BASE_12) begin
      put_bits(32'b011, 3);
      put_bits(offs - lzbtd_pkg::BASE_9, 9);
    end else if (offs < lzbtd_pkg::BASE_20) begin
      put_bits(32'b0111, 4);
      put_bits(offs - lzbtd_pkg::BASE_12, 12);
    end else begin
      put_bits(32'b1111, 4);
      put_bits(offs - lzbtd_pkg::BASE_20, 20);
      base_len = 2;
    end
    put_bits((32'd1 << ones) - 1, ones);
    put_bits(32'h0, 1);
    put_bits(v, ones);
    enc_produced += base_len + (32'd1 << ones) + v;
    flush_bytes();
  endtask

  task automatic put_overflow();
    put_bits(32'b01, 2);
    put_bits('0, 6);
    put_bits((32'd1 << lzbtd_pkg::PREFIX_OVER) - 1, lzbtd_pkg::PREFIX_OVER);
    finish_bits();
  endtask

  task automatic put_end();
    put_bits(32'b1111, 4);
    put_bits(32'(lzbtd_pkg::END_MARK), 20);
    finish_bits();
  endtask

  task automatic trail_noise();
    repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(0, 255)), 1'b0);
  endtask

  function automatic int unsigned pick_dist();
    int unsigned form, hi;
    form = $urandom_range(0, 3);
    if (form == 3 && enc_produced >= lzbtd_pkg::BASE_20) begin
      hi = (enc_produced < FAR_DIST) ? enc_produced : FAR_DIST;
      return $urandom_range(hi, lzbtd_pkg::BASE_20);
    end
    if (form >= 2 && enc_produced >= lzbtd_pkg::BASE_12) begin
      hi = (enc_produced < lzbtd_pkg::BASE_20 - 1) ? enc_produced : lzbtd_pkg::BASE_20 - 1;
      return $urandom_range(hi, lzbtd_pkg::BASE_12);
    end
    if (form >= 1 && enc_produced >= lzbtd_pkg::BASE_9) begin
      hi = (enc_produced < lzbtd_pkg::BASE_12 - 1) ? enc_produced : lzbtd_pkg::BASE_12 - 1;
      return $urandom_range(hi, lzbtd_pkg::BASE_9);
    end
    hi = (enc_produced < lzbtd_pkg::BASE_9 - 1) ? enc_produced : lzbtd_pkg::BASE_9 - 1;
    return $urandom_range(hi, 1);
  endfunction

  // one stream: mostly well formed, now and then broken or abandoned
  task automatic gen_stream(int unsigned n_tok);
    int unsigned dice, ones;
    if ($urandom_range(0, 29) == 0) begin
      open_stream(1'b1, 8'($urandom_range(1, 255)));
      trail_noise();
      return;
    end
    open_stream(1'b1, 8'h00);
    // long copies early so that the wide offsets come into reach
    if ($urandom_range(0, 9) == 0) begin
      put_literal(8'($urandom_range(0, 255)));
      put_copy(1, MAX_ONES, $urandom_range(0, (1 << MAX_ONES) - 1));
    end
    repeat (n_tok) begin
      dice = $urandom_range(0, 99);
      ones = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_ONES) : $urandom_range(0, 3);
      if (dice < 50 || enc_produced == 0) begin
        put_literal(8'($urandom_range(0, 255)));
      end else if (dice < 94) begin
        put_copy(pick_dist(), ones, $urandom_range(0, (1 << ones) - 1));
      end else if (dice < 96) begin
        put_copy(enc_produced + $urandom_range(1, 64), ones, 0);
        finish_bits();
        if ($urandom_range(0, 1) == 0) trail_noise();
        return;
      end else if (dice < 98) begin
        put_overflow();
        if ($urandom_range(0, 1) == 0) trail_noise();
        return;
      end else begin
        // garbage mid-stream, then the next start word abandons it
        trail_noise();
        return;
      end
    end
    put_end();
    if ($urandom_range(0, 3) == 0) trail_noise();
  endtask

  task automatic run_streams(int n);
    int target;
    target = sent + n;
    while (sent < target) gen_stream($urandom_range(1, 40));
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    sent        = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // flag word taken without a start marker straight after reset
    open_stream(1'b0, 8'h00);
    put_literal(8'h00);
    put_literal(8'hFF);
    put_copy(1, 0, 0);
    put_copy(1, MAX_ONES, (1 << MAX_ONES) - 1);
    put_copy(lzbtd_pkg::BASE_9 - 1, 1, 1);
    put_copy(lzbtd_pkg::BASE_9, 2, 0);
    put_copy(lzbtd_pkg::BASE_12 - 1, 0, 0);
    put_copy(1, MAX_ONES, 0);
    put_copy(lzbtd_pkg::BASE_12, 3, 5);
    put_copy(lzbtd_pkg::BASE_20 - 1, 0, 1);
    put_copy(lzbtd_pkg::BASE_20, MAX_ONES, (1 << MAX_ONES) - 1);
    put_end();
    send_word(8'h7E, 1'b0);
    // offset reaching before the start, widest form
    open_stream(1'b1, 8'h00);
    put_copy(FAR_DIST, 0, 0);
    finish_bits();
    open_stream(1'b1, 8'hA5);
    send_word(8'h3C, 1'b0);
    open_stream(1'b1, 8'h00);
    put_literal(8'h96);
    put_overflow();
    // capacity dropped below what the stream has already produced
    open_stream(1'b1, 8'h00);
    repeat (5) put_literal(8'($urandom_range(0, 255)));
    set_capacity(2);
    put_literal(8'($urandom_range(0, 255)));
    finish_bits();
    // copy breaks both room and offset: room wins
    set_capacity(3);
    open_stream(1'b1, 8'h00);
    put_literal(8'h11);
    put_copy(50, 3, 1);
    finish_bits();

    set_capacity(1);
    run_streams(150);
    set_capacity(40);
    run_streams(350);
    set_capacity(24'($urandom_range(200, 20000)));
    run_streams(450);
    set_capacity(lzbtd_pkg::CAP_RESET);
    // receiver holds off while literals keep coming
    hold_req <= 1'b1;
    open_stream(1'b1, 8'h00);
    repeat (40) put_literal(8'($urandom_range(0, 255)));
    put_end();
    run_streams(400);
    drain();
    quiet = 1'b1;
    run_streams(300);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
